// File: src/concentration_inversion_solubility_assert.svh
// Assertion macros used by the concentration inversion front end.
`ifndef CONCENTRATION_INVERSION_SOLUBILITY_ASSERT_SVH
`define CONCENTRATION_INVERSION_SOLUBILITY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CIS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CIS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/cis_pkg.sv
// Shared types, constants and saturating arithmetic for the concentration inversion block.
package cis_pkg;

    localparam int DIV_STEPS = 96;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int MUL_LAT   = 2;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic signed [63:0] QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] QMIN = 64'sh8000_0000_0000_0000;

    localparam int ADDR_W = 5;
    localparam logic [1:0] REG_TOL   = 2'd0;
    localparam logic [1:0] REG_KEEP  = 2'd1;
    localparam logic [1:0] REG_TRACK = 2'd2;

    typedef struct packed {
        logic [62:0] tol;
        logic        keep;
        logic        track;
    } t_cfg;

    typedef struct packed {
        logic signed [63:0] wn;
        logic signed [63:0] ws;
        logic signed [63:0] q;
        logic signed [63:0] s;
        logic [62:0]        cv;
        logic signed [63:0] lim;
        logic signed [63:0] wt;
        logic signed [63:0] thr;
        logic signed [63:0] c;
        logic signed [63:0] row;
        logic signed [63:0] d;
        logic               precip;
        logic               diss;
    } t_item;

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic [64:0] t;
        t = {a[63], a} + {b[63], b};
        if (t[64] != t[63]) return t[64] ? QMIN : QMAX;
        return $signed(t[63:0]);
    endfunction

    function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic [64:0] t;
        t = {a[63], a} - {b[63], b};
        if (t[64] != t[63]) return t[64] ? QMIN : QMAX;
        return $signed(t[63:0]);
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic signed [63:0] sat_mag(input logic [63:0] m, input logic neg,
                                                   input logic ovf);
        if (neg) begin
            return (ovf || m[63]) ? QMIN : $signed(-m);
        end
        return (ovf || m[63]) ? QMAX : $signed(m);
    endfunction

endpackage

// File: src/cis_div.sv
// Pipelined Q31.32 saturating divider, one quotient bit per stage.
module cis_div import cis_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_valid,
    output logic signed [63:0] o_q
);

    logic        r_v    [0:DIV_STEPS];
    logic [63:0] r_rem  [0:DIV_STEPS];
    logic [63:0] r_q    [0:DIV_STEPS];
    logic        r_ovf  [0:DIV_STEPS];
    logic [63:0] r_ua   [0:DIV_STEPS];
    logic [63:0] r_ub   [0:DIV_STEPS];
    logic        r_neg  [0:DIV_STEPS];
    logic        r_zero [0:DIV_STEPS];
    logic        r_apos [0:DIV_STEPS];
    logic        r_aneg [0:DIV_STEPS];
    logic               r_out_v;
    logic signed [63:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_q[0]    <= '0;
        r_ovf[0]  <= 1'b0;
        r_ua[0]   <= mag(i_a);
        r_ub[0]   <= mag(i_b);
        r_neg[0]  <= i_a[63] != i_b[63];
        r_zero[0] <= i_b == 64'sd0;
        r_apos[0] <= i_a > 64'sd0;
        r_aneg[0] <= i_a[63];
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic        bit_in;
        logic [63:0] rem_s;
        logic        ge;

        if (k < 64) begin : g_hi
            assign bit_in = r_ua[k][63-k];
        end else begin : g_lo
            assign bit_in = 1'b0;
        end
        assign rem_s = {r_rem[k][62:0], bit_in};
        assign ge    = rem_s >= r_ub[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= ge ? rem_s - r_ub[k] : rem_s;
            r_q[k+1]    <= {r_q[k][62:0], ge};
            r_ovf[k+1]  <= r_ovf[k] | r_q[k][63];
            r_ua[k+1]   <= r_ua[k];
            r_ub[k+1]   <= r_ub[k];
            r_neg[k+1]  <= r_neg[k];
            r_zero[k+1] <= r_zero[k];
            r_apos[k+1] <= r_apos[k];
            r_aneg[k+1] <= r_aneg[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_zero[DIV_STEPS]) begin
            r_out <= r_apos[DIV_STEPS] ? QMAX : (r_aneg[DIV_STEPS] ? QMIN : 64'sd0);
        end else begin
            r_out <= sat_mag(r_q[DIV_STEPS], r_neg[DIV_STEPS], r_ovf[DIV_STEPS]);
        end
    end

    assign o_valid = r_out_v;
    assign o_q     = r_out;

endmodule

// File: src/cis_mul.sv
// Two-stage Q31.32 saturating multiplier built from four 32x32 partial products.
module cis_mul import cis_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_valid,
    output logic signed [63:0] o_p
);

    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] r_p00;
    logic [63:0] r_p01;
    logic [63:0] r_p10;
    logic [63:0] r_p11;
    logic        r_neg;
    logic        r_v;
    logic        r_out_v;
    logic signed [63:0] r_out;
    logic [33:0] s;
    logic [63:0] hi;
    logic        ovf;

    assign ua = mag(i_a);
    assign ub = mag(i_b);

    always_ff @(posedge i_clk) begin
        r_p00 <= ua[31:0]  * ub[31:0];
        r_p01 <= ua[31:0]  * ub[63:32];
        r_p10 <= ua[63:32] * ub[31:0];
        r_p11 <= ua[63:32] * ub[63:32];
        r_neg <= i_a[63] != i_b[63];
    end

    assign s   = 34'(r_p00[63:32]) + 34'(r_p01[31:0]) + 34'(r_p10[31:0]);
    assign hi  = r_p11 + 64'(r_p01[63:32]) + 64'(r_p10[63:32]) + 64'(s[33:32]);
    assign ovf = hi[63:32] != 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_v     <= i_valid;
            r_out_v <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= sat_mag({hi[31:0], s[31:0]}, r_neg, ovf);
    end

    assign o_valid = r_out_v;
    assign o_p     = r_out;

endmodule

// File: src/cis_front.sv
// Front end: configuration registers, request intake and the request queue.
`include "concentration_inversion_solubility_assert.svh"
module cis_front import cis_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [63:0] i_liquid_water,
    input  logic signed [63:0] i_water_outflow,
    input  logic signed [63:0] i_conserved_amount,
    input  logic signed [63:0] i_solid_amount,
    input  logic [62:0]        i_cell_volume,
    input  logic signed [63:0] i_solubility_limit,
    output t_cfg               o_cfg,
    output logic               o_valid,
    output t_item              o_item
);

    t_cfg              r_cfg;
    t_item             r_fifo [0:QDEPTH-1];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;
    logic              cfg_wr;
    t_item             n_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tol   <= '0;
            r_cfg.keep  <= 1'b0;
            r_cfg.track <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_TOL:   r_cfg.tol   <= pwdata[62:0];
                REG_KEEP:  r_cfg.keep  <= pwdata[0];
                REG_TRACK: r_cfg.track <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_TOL:   prdata = {1'b0, r_cfg.tol};
            REG_KEEP:  prdata = {63'd0, r_cfg.keep};
            REG_TRACK: prdata = {63'd0, r_cfg.track};
            default:   prdata = '0;
        endcase
    end

    assign busy = r_count == QCNT_W'(QDEPTH);
    assign push = start && !busy;
    assign pop  = r_count != '0;

    always_comb begin
        n_item     = '0;
        n_item.wn  = i_liquid_water;
        n_item.ws  = i_water_outflow;
        n_item.q   = i_conserved_amount;
        n_item.s   = i_solid_amount;
        n_item.cv  = i_cell_volume;
        n_item.lim = i_solubility_limit;
        n_item.wt  = sadd(i_water_outflow, i_liquid_water);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    assign o_cfg   = r_cfg;
    assign o_valid = pop;
    assign o_item  = r_fifo[r_rd_ptr];

    `CIS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QDEPTH))
    `CIS_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + 1'b1)
    `CIS_ASSERT_NEXT(a_drain, i_clk, i_rst_n, pop && !push, r_count == $past(r_count) - 1'b1)

endmodule

// File: src/cis_back.sv
// Back end: threshold and concentration division, precipitation and dissolution pipeline.
module cis_back import cis_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_valid,
    output t_item              o_item
);

    logic               thr_v;
    logic signed [63:0] thr_q;
    logic               cdiv_v;
    logic signed [63:0] cdiv_q;
    logic               m1_v;
    logic signed [63:0] m1_p;
    logic               m2_v;
    logic signed [63:0] m2_p;
    logic               d3_v;
    logic signed [63:0] d3_q;
    logic               d3_unused;

    t_item r_dl1 [0:DIV_LAT-1];
    t_item r_dl2 [0:MUL_LAT-1];
    t_item r_dl3 [0:MUL_LAT-1];
    t_item r_dl4 [0:DIV_LAT-1];

    t_item              r_s1;
    logic               r_s1_v;
    t_item              r_s2;
    logic               r_s2_v;
    logic signed [63:0] r_op1;
    t_item              r_s3;
    logic               r_s3_v;
    t_item              r_s4;
    logic               r_s4_v;
    logic signed [63:0] r_op2;
    t_item              r_s5;
    logic               r_s5_v;
    t_item              r_out;
    logic               r_out_v;

    t_item n_s1;
    t_item n_s3;
    t_item n_s4;
    t_item n_s5;
    t_item n_out;
    logic  wet;
    logic  outflow;

    cis_div u_div_thr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_a     ($signed({1'b0, i_cfg.tol})),
        .i_b     ($signed({1'b0, i_item.cv})),
        .o_valid (thr_v),
        .o_q     (thr_q)
    );

    cis_div u_div_conc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_a     (i_item.q),
        .i_b     (i_item.wt),
        .o_valid (cdiv_v),
        .o_q     (cdiv_q)
    );

    always_ff @(posedge i_clk) begin
        r_dl1[0] <= i_item;
        for (int k = 1; k < DIV_LAT; k++) r_dl1[k] <= r_dl1[k-1];
    end

    always_comb begin
        n_s1     = r_dl1[DIV_LAT-1];
        n_s1.thr = (n_s1.cv == '0) ? QMAX : thr_q;
        wet      = (n_s1.wn > n_s1.thr) && (n_s1.q > 64'sd0);
        outflow  = (n_s1.ws > n_s1.thr) && (n_s1.q > 64'sd0);
        n_s1.row    = n_s1.ws;
        n_s1.c      = 64'sd0;
        n_s1.precip = 1'b0;
        n_s1.diss   = 1'b0;
        if (wet) begin
            n_s1.c      = cdiv_q;
            n_s1.row    = i_cfg.keep ? n_s1.wt : n_s1.ws;
            n_s1.precip = i_cfg.track && (n_s1.lim > 64'sd0) && (cdiv_q > n_s1.lim);
        end else if (!outflow) begin
            if (i_cfg.track && (n_s1.q > 64'sd0)) n_s1.s = sadd(n_s1.s, n_s1.q);
            n_s1.q = 64'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_s2  <= r_s1;
        r_op1 <= ssub(r_s1.c, r_s1.lim);
    end

    cis_mul u_mul_precip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_v),
        .i_a     (r_op1),
        .i_b     (r_s2.wt),
        .o_valid (m1_v),
        .o_p     (m1_p)
    );

    always_ff @(posedge i_clk) begin
        r_dl2[0] <= r_s2;
        for (int k = 1; k < MUL_LAT; k++) r_dl2[k] <= r_dl2[k-1];
    end

    always_comb begin
        n_s3 = r_dl2[MUL_LAT-1];
        if (n_s3.precip) begin
            n_s3.s = sadd(n_s3.s, m1_p);
            n_s3.c = n_s3.lim;
        end
    end

    always_comb begin
        n_s4      = r_s3;
        n_s4.diss = i_cfg.track && (r_s3.wt > r_s3.thr) && (r_s3.s > 64'sd0)
                    && (r_s3.c < r_s3.lim);
    end

    always_ff @(posedge i_clk) begin
        r_s3  <= n_s3;
        r_s4  <= n_s4;
        r_op2 <= ssub(r_s3.lim, r_s3.c);
    end

    cis_mul u_mul_diss (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s4_v),
        .i_a     (r_op2),
        .i_b     (r_s4.wt),
        .o_valid (m2_v),
        .o_p     (m2_p)
    );

    always_ff @(posedge i_clk) begin
        r_dl3[0] <= r_s4;
        for (int k = 1; k < MUL_LAT; k++) r_dl3[k] <= r_dl3[k-1];
    end

    always_comb begin
        n_s5   = r_dl3[MUL_LAT-1];
        n_s5.d = (n_s5.s < m2_p) ? n_s5.s : m2_p;
    end

    always_ff @(posedge i_clk) begin
        r_s5 <= n_s5;
    end

    cis_div u_div_diss (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s5_v),
        .i_a     (r_s5.d),
        .i_b     (r_s5.wn),
        .o_valid (d3_v),
        .o_q     (d3_q)
    );

    always_ff @(posedge i_clk) begin
        r_dl4[0] <= r_s5;
        for (int k = 1; k < DIV_LAT; k++) r_dl4[k] <= r_dl4[k-1];
    end

    always_comb begin
        n_out = r_dl4[DIV_LAT-1];
        if (n_out.diss) begin
            if (n_out.wn > n_out.thr) n_out.c = sadd(n_out.c, d3_q);
            n_out.s = ssub(n_out.s, n_out.d);
            n_out.q = sadd(n_out.q, n_out.d);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_s1_v  <= thr_v && cdiv_v;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= m1_v;
            r_s4_v  <= r_s3_v;
            r_s5_v  <= m2_v;
            r_out_v <= d3_v;
        end
    end

    assign d3_unused = 1'b0;
    assign o_valid   = r_out_v | d3_unused;
    assign o_item    = r_out;

endmodule

// File: src/concentration_inversion_solubility.sv
// Top level of the concentration inversion block with solubility limit.
//
//  channel   | signals                                  | direction
//  ----------+------------------------------------------+-----------
//  request   | start, busy, i_liquid_water .. limit     | in / out
//  result    | o_valid, o_new_concentration .. row      | out
//  config    | psel, penable, pwrite, paddr, pwdata     | in / out
//
// One request is taken per cycle while busy is low; busy rises only when the request queue is full.
// A request passes the queue, the threshold and concentration dividers side by side, the
// precipitation multiplier, the dissolution multiplier and divider and six pipeline registers.
// Reset is synchronous and active low; it clears the queue and all valid bits.
// Results are shown for exactly one cycle with o_valid and cannot be held off.
module concentration_inversion_solubility import cis_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [63:0] i_liquid_water,
    input  logic signed [63:0] i_water_outflow,
    input  logic signed [63:0] i_conserved_amount,
    input  logic signed [63:0] i_solid_amount,
    input  logic [62:0]        i_cell_volume,
    input  logic signed [63:0] i_solubility_limit,
    output logic               o_valid,
    output logic signed [63:0] o_new_concentration,
    output logic signed [63:0] o_new_conserved,
    output logic signed [63:0] o_new_solid,
    output logic signed [63:0] o_new_water_row
);

    t_cfg  cfg;
    logic  q_valid;
    t_item q_item;
    t_item res;

    cis_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .start              (start),
        .busy               (busy),
        .i_liquid_water     (i_liquid_water),
        .i_water_outflow    (i_water_outflow),
        .i_conserved_amount (i_conserved_amount),
        .i_solid_amount     (i_solid_amount),
        .i_cell_volume      (i_cell_volume),
        .i_solubility_limit (i_solubility_limit),
        .o_cfg              (cfg),
        .o_valid            (q_valid),
        .o_item             (q_item)
    );

    cis_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_valid (o_valid),
        .o_item  (res)
    );

    assign o_new_concentration = res.c;
    assign o_new_conserved     = res.q;
    assign o_new_solid         = res.s;
    assign o_new_water_row     = res.row;

endmodule

// File: verif/concentration_inversion_solubility_checker.sv
// Checker that predicts and compares every result of the concentration inversion block.
`timescale 1ns / 1ps

module concentration_inversion_solubility_checker import cis_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [63:0]        pwdata,
    input  logic               pready,
    input  logic               start,
    input  logic               busy,
    input  logic signed [63:0] i_liquid_water,
    input  logic signed [63:0] i_water_outflow,
    input  logic signed [63:0] i_conserved_amount,
    input  logic signed [63:0] i_solid_amount,
    input  logic [62:0]        i_cell_volume,
    input  logic signed [63:0] i_solubility_limit,
    input  logic               o_valid,
    input  logic signed [63:0] o_new_concentration,
    input  logic signed [63:0] o_new_conserved,
    input  logic signed [63:0] o_new_solid,
    input  logic signed [63:0] o_new_water_row,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    typedef struct packed {
        logic signed [63:0] conc;
        logic signed [63:0] conserved;
        logic signed [63:0] solid;
        logic signed [63:0] water_row;
    } t_cell_result;

    t_cell_result cell_result_q[$];
    logic [62:0]  tol_reg;
    logic         keep_reg;
    logic         track_reg;

    function automatic logic signed [63:0] clamp_mag(input logic [63:0] m, input logic neg,
                                                     input logic ovf);
        if (neg) begin
            return (ovf || m[63]) ? QMIN : -$signed(m);
        end
        return (ovf || m[63]) ? QMAX : $signed(m);
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic signed [63:0] q_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] t;
        t = 65'(a) + 65'(b);
        if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) return QMAX;
        if (t < -65'sh0_8000_0000_0000_0000) return QMIN;
        return t[63:0];
    endfunction

    function automatic logic signed [63:0] q_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] t;
        t = 65'(a) - 65'(b);
        if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) return QMAX;
        if (t < -65'sh0_8000_0000_0000_0000) return QMIN;
        return t[63:0];
    endfunction

    function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic [127:0] p;
        p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        p = p >> 32;
        return clamp_mag(p[63:0], a[63] != b[63], p[127:64] != 0);
    endfunction

    function automatic logic signed [63:0] q_div(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic [127:0] n;
        logic [127:0] quo;
        if (b == 0) return (a > 0) ? QMAX : ((a < 0) ? QMIN : 64'sd0);
        n = {64'd0, abs64(a)} << 32;
        quo = n / {64'd0, abs64(b)};
        return clamp_mag(quo[63:0], a[63] != b[63], quo[127:64] != 0);
    endfunction

    function automatic t_cell_result predict_cell(input logic signed [63:0] wn,
                                                  input logic signed [63:0] ws,
                                                  input logic signed [63:0] q_in,
                                                  input logic signed [63:0] s_in,
                                                  input logic [62:0] cv,
                                                  input logic signed [63:0] lim);
        logic signed [63:0] thr, wt, c, row, q, s, d;
        t_cell_result r;
        q = q_in;
        s = s_in;
        thr = (cv == 0) ? QMAX : q_div($signed({1'b0, tol_reg}), $signed({1'b0, cv}));
        wt = q_add(ws, wn);
        row = ws;
        if (wn > thr && q > 0) begin
            c = q_div(q, wt);
            if (keep_reg) row = wt;
            if (track_reg && lim > 0 && c > lim) begin
                s = q_add(s, q_mul(q_sub(c, lim), wt));
                c = lim;
            end
        end else if (ws > thr && q > 0) begin
            c = 0;
        end else begin
            if (track_reg && q > 0) s = q_add(s, q);
            q = 0;
            c = 0;
        end
        if (track_reg && wt > thr && s > 0 && c < lim) begin
            d = q_mul(q_sub(lim, c), wt);
            if (s < d) d = s;
            if (wn > thr) c = q_add(c, q_div(d, wn));
            s = q_sub(s, d);
            q = q_add(q, d);
        end
        r.conc = c;
        r.conserved = q;
        r.solid = s;
        r.water_row = row;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_checked = 0;
    end

    assign o_pending = cell_result_q.size();

    always @(posedge i_clk) begin
        t_cell_result want;
        if (!i_rst_n) begin
            tol_reg <= '0;
            keep_reg <= 1'b0;
            track_reg <= 1'b1;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_TOL, 3'b000}) tol_reg <= pwdata[62:0];
                if (paddr == {REG_KEEP, 3'b000}) keep_reg <= pwdata[0];
                if (paddr == {REG_TRACK, 3'b000}) track_reg <= pwdata[0];
            end
            if (start && !busy) begin
                cell_result_q.push_back(predict_cell(i_liquid_water, i_water_outflow,
                    i_conserved_amount, i_solid_amount, i_cell_volume, i_solubility_limit));
            end
            if (o_valid) begin
                if (cell_result_q.size() == 0) begin
                    report_mismatch("unexpected result", o_new_concentration, 64'd0);
                end else begin
                    want = cell_result_q.pop_front();
                    o_checked++;
                    if (o_new_concentration !== want.conc)
                        report_mismatch("concentration", o_new_concentration, want.conc);
                    if (o_new_conserved !== want.conserved)
                        report_mismatch("conserved", o_new_conserved, want.conserved);
                    if (o_new_solid !== want.solid)
                        report_mismatch("solid", o_new_solid, want.solid);
                    if (o_new_water_row !== want.water_row)
                        report_mismatch("water row", o_new_water_row, want.water_row);
                end
            end
        end
    end

endmodule

// File: verif/concentration_inversion_solubility_test.sv
// Testbench top for the concentration inversion block: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module concentration_inversion_solubility_test;
    import cis_pkg::*;

    localparam logic signed [63:0] ONE = 64'sh1_0000_0000;
    localparam int PHASE_ITEMS = 105;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite, pready;
    logic [ADDR_W-1:0]  paddr;
    logic [63:0]        pwdata, prdata;
    logic               start, busy;
    logic signed [63:0] liquid_water, water_outflow, conserved, solid, limit;
    logic [62:0]        volume;
    logic               o_valid;
    logic signed [63:0] new_conc, new_conserved, new_solid, new_row;
    int                 fail_count, pending, checked;
    logic               allow_idle;

    concentration_inversion_solubility i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .i_liquid_water(liquid_water), .i_water_outflow(water_outflow),
        .i_conserved_amount(conserved), .i_solid_amount(solid),
        .i_cell_volume(volume), .i_solubility_limit(limit),
        .o_valid(o_valid), .o_new_concentration(new_conc),
        .o_new_conserved(new_conserved), .o_new_solid(new_solid),
        .o_new_water_row(new_row)
    );

    concentration_inversion_solubility_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .start(start), .busy(busy),
        .i_liquid_water(liquid_water), .i_water_outflow(water_outflow),
        .i_conserved_amount(conserved), .i_solid_amount(solid),
        .i_cell_volume(volume), .i_solubility_limit(limit),
        .o_valid(o_valid), .o_new_concentration(new_conc),
        .o_new_conserved(new_conserved), .o_new_solid(new_solid),
        .o_new_water_row(new_row),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain_results();
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Called at a falling edge; returns at a falling edge once the request is taken.
    task automatic send_cell(input logic signed [63:0] wn, input logic signed [63:0] ws,
                             input logic signed [63:0] q, input logic signed [63:0] s,
                             input logic [62:0] cv, input logic signed [63:0] lim);
        liquid_water = wn;
        water_outflow = ws;
        conserved = q;
        solid = s;
        volume = cv;
        limit = lim;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    function automatic logic signed [63:0] any_value();
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 1 << 20)) << 12;
            2: return -(64'($urandom_range(0, 1 << 20)) << 12);
            3: begin
                case ($urandom_range(0, 4))
                    0: return QMAX;
                    1: return QMIN;
                    2: return 64'sd0;
                    3: return 64'sd1;
                    default: return -64'sd1;
                endcase
            end
            4: return 64'($urandom) << $urandom_range(0, 31);
            default: return -(64'($urandom) << $urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [62:0] any_volume();
        case ($urandom_range(0, 5))
            0: return 63'({$urandom, $urandom} >> 1);
            1: return 63'd0;
            2: return 63'h7FFF_FFFF_FFFF_FFFF;
            default: return 63'($urandom_range(1, 1 << 16)) << 24;
        endcase
    endfunction

    task automatic random_cells(input int count);
        logic signed [63:0] wn, ws, q, s, lim;
        logic [62:0] cv;
        repeat (count) begin
            if ($urandom_range(0, 9) < 7) begin
                wn = 64'($urandom_range(0, 1 << 24)) << $urandom_range(8, 28);
                ws = ($urandom_range(0, 1)) ? 64'($urandom_range(0, 1 << 20)) << 12
                                           : -(64'($urandom_range(0, 1 << 20)) << 8);
                q = 64'($urandom_range(1, 1 << 24)) << $urandom_range(4, 30);
                s = ($urandom_range(0, 2) == 0) ? 64'sd0
                                              : 64'($urandom_range(0, 1 << 24)) << 12;
                lim = ($urandom_range(0, 4) == 0) ? -(64'($urandom_range(0, 1 << 20)) << 8)
                                                 : 64'($urandom_range(0, 1 << 24)) << 12;
                cv = 63'($urandom_range(1, 1 << 16)) << 24;
                if ($urandom_range(0, 5) == 0) wn = -wn;
            end else begin
                wn = any_value();
                ws = any_value();
                q = any_value();
                s = any_value();
                lim = any_value();
                cv = any_volume();
            end
            send_cell(wn, ws, q, s, cv, lim);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        liquid_water = '0;
        water_outflow = '0;
        conserved = '0;
        solid = '0;
        volume = '0;
        limit = '0;
        allow_idle = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_cell(0, 0, 0, 0, 0, 0);
        send_cell(QMAX, QMAX, QMAX, QMAX, 63'h7FFF_FFFF_FFFF_FFFF, QMAX);
        send_cell(QMIN, QMIN, QMIN, QMIN, 63'd1, QMIN);
        send_cell(10 * ONE, 0, 100 * ONE, 0, 63'(ONE), 2 * ONE);
        send_cell(10 * ONE, ONE, 5 * ONE, 40 * ONE, 63'(ONE), 2 * ONE);
        send_cell(-ONE, 3 * ONE, 7 * ONE, ONE, 63'(ONE), 4 * ONE);
        send_cell(0, -ONE, 9 * ONE, 2 * ONE, 63'(ONE), 4 * ONE);
        send_cell(5 * ONE, -5 * ONE, 3 * ONE, 0, 63'(ONE), ONE);
        send_cell(5 * ONE, 0, 3 * ONE, ONE, 63'd0, ONE);
        send_cell(5 * ONE, ONE, 3 * ONE, 6 * ONE, 63'(ONE), -2 * ONE);
        send_cell(5 * ONE, ONE, 3 * ONE, 6 * ONE, 63'(ONE), 0);
        send_cell(ONE, 0, QMAX, 0, 63'(ONE), ONE);
        send_cell(64'sd1, 0, QMAX, QMAX, 63'd1, QMAX);
        send_cell(ONE, ONE, -ONE, 8 * ONE, 63'(ONE), 3 * ONE);
        start = 1'b0;
        drain_results();

        allow_idle = 1'b1;
        random_cells(PHASE_ITEMS);
        start = 1'b0;
        drain_results();

        write_reg(REG_TOL, 64'h7FFF_FFFF_FFFF_FFFF);
        write_reg(REG_KEEP, 64'd1);
        write_reg(REG_TRACK, 64'd0);
        @(negedge i_clk);
        random_cells(PHASE_ITEMS);
        start = 1'b0;
        drain_results();

        write_reg(REG_TOL, 64'(ONE));
        write_reg(REG_TRACK, 64'd1);
        @(negedge i_clk);
        random_cells(PHASE_ITEMS);
        start = 1'b0;
        drain_results();

        write_reg(REG_TOL, {$urandom, $urandom} >> 1);
        write_reg(REG_KEEP, 64'd0);
        @(negedge i_clk);
        random_cells(PHASE_ITEMS);
        start = 1'b0;
        drain_results();

        write_reg(REG_TOL, 64'd0);
        write_reg(REG_KEEP, 64'd1);
        @(negedge i_clk);
        allow_idle = 1'b0;
        random_cells(PHASE_ITEMS);
        start = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
        $display("Checked %0d cells over five register settings, including dry, outflow,",
                 checked);
        $display("precipitation, dissolution, zero volume and saturating extremes.");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
